/* rtl/tcgr_pkg.sv */
// tcgr_pkg: shared types, codes and constants of the text console glyph renderer
// used by text_console_glyph_renderer; no dependencies
package tcgr_pkg;

    // font geometry
    localparam int GLYPH_WIDTH      = 8;
    localparam int GLYPH_ROWS_DEF   = 15;
    localparam int GLYPH_COUNT      = 128;

    // glyph store: code times 16 plus row
    localparam int STORE_DEPTH      = 2048;
    localparam int STORE_AW         = 11;
    localparam int ROW_SHIFT        = 4;
    localparam int CODE_BITS        = STORE_AW - ROW_SHIFT;

    // widest visible screen
    localparam logic [10:0] MAX_WIDTH = 11'd1024;

    // register reset values
    localparam logic [10:0] WIDTH_RST  = 11'd1024;
    localparam logic [9:0]  HEIGHT_RST = 10'd768;
    localparam logic [5:0]  LINE_RST   = 6'd16;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_HEIGHT   = 2'd2;

    // input operations
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PUT  = 1'b1;

    // result kinds
    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // special characters
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    typedef struct packed {
        logic        op;
        logic [7:0]  char_code;
        logic [15:0] colour;
        logic [10:0] font_index;
        logic [7:0]  font_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [7:0]  pixel_mask;
        logic [15:0] pixel_colour;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_LINE,
        S_ROWS,
        S_FIN,
        S_SCROLL
    } t_state;

endpackage

/* rtl/tcgr_ram.sv */
// tcgr_ram: generic single-port-write, single-port-read RAM with registered read
// no dependencies
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/text_console_glyph_renderer.sv */
// text_console_glyph_renderer: cursor, sequencer and row pipeline of the text console
// depends on tcgr_pkg and tcgr_ram
//
// A load transaction writes one font byte into the 2048 x 8 glyph store. A put
// transaction of a drawable character runs in this order: the shared add/compare
// unit decides the column wrap and then the line advance, one glyph-store read per
// row goes through the single read port of the store, the read pipeline drains,
// the cursor is updated and, when the screen scrolls, a scroll command is sent.
// Each glyph has GLYPH_ROWS rows, 15 by default. A space, a code at or above 128
// or a newline skips the glyph-store reads. The input
// is stalled for the whole time a put transaction is in work. Results leave through
// an output register, so the next row is prepared while the current one waits.
module text_console_glyph_renderer #(
    parameter int GLYPH_ROWS = tcgr_pkg::GLYPH_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcgr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcgr_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [10:0]         i_cfg_data
);

    import tcgr_pkg::*;

    localparam int             RW       = $clog2(GLYPH_ROWS);
    localparam logic [RW-1:0]  ROW_LAST = RW'(GLYPH_ROWS - 1);

    // configuration registers
    logic [10:0] r_width;
    logic [9:0]  r_height;
    logic [5:0]  r_lh;

    // cursor and sequencer state
    t_state      r_state, n_state;
    logic [9:0]  r_col, n_col;
    logic [9:0]  r_row, n_row;
    logic [7:0]  r_code, n_code;
    logic [15:0] r_colour, n_colour;
    logic        r_nl, n_nl;
    logic        r_draw, n_draw;
    logic        r_wrap, n_wrap;
    logic        r_scroll, n_scroll;
    logic [9:0]  r_next_col, n_next_col;
    logic [9:0]  r_next_row, n_next_row;
    logic [7:0]  r_clip, n_clip;
    logic [RW-1:0] r_ridx, n_ridx;

    // read pipeline stage and output register
    logic        r_b_valid, n_b_valid;
    logic [9:0]  r_b_y, n_b_y;
    logic        r_b_vis, n_b_vis;
    logic        r_b_last, n_b_last;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic [10:0] w_width;
    logic [9:0]  su_a;
    logic [5:0]  su_b;
    logic [10:0] su_c;
    logic [10:0] su_sum;
    logic        su_ge;
    logic [7:0]  w_clip;
    logic [9:0]  w_bottom;
    logic        w_in_acc;
    logic        w_can_go;
    logic        w_b_move;
    logic        w_a_fire;
    logic        w_ram_we;
    logic [STORE_AW-1:0] w_raddr;
    logic [7:0]  w_rdata;

    // handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_can_go    = !r_out_valid || !i_out_stall;
    assign w_b_move    = r_b_valid && w_can_go;
    assign w_a_fire    = (r_state == S_ROWS) && (!r_b_valid || w_can_go);

    // effective width, capped at the widest screen
    assign w_width = (r_width > MAX_WIDTH) ? MAX_WIDTH : r_width;

    // shared add and compare unit: operands picked by the sequencer
    always_comb begin
        unique case (r_state)
            S_ADV: begin
                su_a = r_col;
                su_b = 6'(GLYPH_WIDTH);
                su_c = w_width;
            end
            S_LINE: begin
                su_a = r_row;
                su_b = r_lh;
                su_c = {1'b0, r_height};
            end
            default: begin
                su_a = r_row;
                su_b = 6'(r_ridx);
                su_c = {1'b0, r_height};
            end
        endcase
    end

    assign su_sum = 11'(su_a) + 11'(su_b);
    assign su_ge  = (su_sum >= su_c);

    // right-edge clip of the eight glyph pixels
    always_comb begin
        for (int b = 0; b < GLYPH_WIDTH; b++) begin
            w_clip[b] = ((11'(r_col) + 11'(b)) < w_width);
        end
    end

    // bottom line after a scroll
    assign w_bottom = ({4'b0, r_lh} > r_height) ? 10'd0 : (r_height - 10'(r_lh));

    // glyph store
    assign w_ram_we = w_in_acc && (i_in_item.op == OP_LOAD);
    assign w_raddr  = {r_code[CODE_BITS-1:0], ROW_SHIFT'(r_ridx)};

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_in_item.font_index),
        .i_wdata (i_in_item.font_byte),
        .i_re    (w_a_fire),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_code      = r_code;
        n_colour    = r_colour;
        n_nl        = r_nl;
        n_draw      = r_draw;
        n_wrap      = r_wrap;
        n_scroll    = r_scroll;
        n_next_col  = r_next_col;
        n_next_row  = r_next_row;
        n_clip      = r_clip;
        n_ridx      = r_ridx;
        n_b_y       = r_b_y;
        n_b_vis     = r_b_vis;
        n_b_last    = r_b_last;
        n_out       = r_out;
        n_b_valid   = r_b_valid;
        n_out_valid = r_out_valid;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_item.op == OP_PUT)) begin
                    n_code   = i_in_item.char_code;
                    n_colour = i_in_item.colour;
                    n_nl     = (i_in_item.char_code == CHAR_NEWLINE);
                    n_draw   = (i_in_item.char_code != CHAR_NEWLINE)
                            && (i_in_item.char_code != CHAR_SPACE)
                            && ({1'b0, i_in_item.char_code} < 9'(GLYPH_COUNT));
                    n_state  = S_ADV;
                end
            end
            S_ADV: begin
                // column advance and wrap
                n_wrap     = r_nl || su_ge;
                n_next_col = (r_nl || su_ge) ? 10'd0 : su_sum[9:0];
                n_clip     = w_clip;
                n_state    = S_LINE;
            end
            S_LINE: begin
                // line advance and scroll
                n_scroll   = r_wrap && su_ge;
                n_next_row = su_ge ? w_bottom : su_sum[9:0];
                n_ridx     = '0;
                n_state    = r_draw ? S_ROWS : S_FIN;
            end
            S_ROWS: begin
                if (w_a_fire) begin
                    n_b_y    = su_sum[9:0];
                    n_b_vis  = !su_ge;
                    n_b_last = (r_ridx == ROW_LAST) && !r_scroll;
                    if (r_ridx == ROW_LAST) begin
                        n_state = S_FIN;
                    end else begin
                        n_ridx = r_ridx + RW'(1);
                    end
                end
            end
            S_FIN: begin
                // cursor update once the last row has left the pipeline
                if (!r_b_valid) begin
                    n_col = r_next_col;
                    if (r_wrap) begin
                        n_row = r_next_row;
                    end
                    n_state = r_scroll ? S_SCROLL : S_IDLE;
                end
            end
            S_SCROLL: begin
                if (w_can_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // read pipeline stage
        if (w_a_fire) begin
            n_b_valid = 1'b1;
        end else if (w_b_move) begin
            n_b_valid = 1'b0;
        end

        // output register
        priority if (w_b_move) begin
            n_out.kind         = KIND_ROW;
            n_out.pixel_x      = r_col;
            n_out.pixel_y      = r_b_y;
            n_out.pixel_mask   = r_b_vis ? (w_rdata & r_clip) : 8'd0;
            n_out.pixel_colour = r_colour;
            n_out.last         = r_b_last;
            n_out_valid        = 1'b1;
        end else if ((r_state == S_SCROLL) && w_can_go) begin
            n_out.kind         = KIND_SCROLL;
            n_out.pixel_x      = 10'd0;
            n_out.pixel_y      = 10'd0;
            n_out.pixel_mask   = 8'd0;
            n_out.pixel_colour = 16'd0;
            n_out.last         = 1'b1;
            n_out_valid        = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= 10'd0;
            r_row       <= 10'd0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_b_valid   <= n_b_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_lh     <= LINE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data[9:0];
                CFG_LINE_HEIGHT:   r_lh     <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // transaction and row payload registers
    always_ff @(posedge i_clk) begin
        r_code     <= n_code;
        r_colour   <= n_colour;
        r_nl       <= n_nl;
        r_draw     <= n_draw;
        r_wrap     <= n_wrap;
        r_scroll   <= n_scroll;
        r_next_col <= n_next_col;
        r_next_row <= n_next_row;
        r_clip     <= n_clip;
        r_ridx     <= n_ridx;
        r_b_y      <= n_b_y;
        r_b_vis    <= n_b_vis;
        r_b_last   <= n_b_last;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a scroll command always closes its transaction
    a_scroll_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.kind == KIND_SCROLL)) |-> r_out.last)
        else $error("scroll command without last flag");

    // no new transaction while a row is still in the read pipeline
    a_accept_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> (!r_b_valid && (r_state == S_IDLE)))
        else $error("transaction accepted with rows in flight");

    // the read of the last glyph row hands over to the cursor update
    a_last_row_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_a_fire && (r_ridx == ROW_LAST)) |=> (r_state == S_FIN))
        else $error("row sequence did not finish after the last row");

endmodule
